@@ rtl/dctd_pkg.sv @@
package dctd_pkg;

    typedef struct packed {
        logic [15:0] count_a;
        logic [15:0] count_b;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status_a;
        logic [1:0] status_b;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_PRESS   = 2'd1,
        ST_RELEASE = 2'd2
    } t_status;

    typedef struct packed {
        logic press_hit;
        logic press_clear;
        logic rel_hit;
        logic rel_clear;
    } t_hp_flags;

    typedef struct packed {
        t_hp_flags take;
        t_hp_flags hold;
        logic      skip_match;
    } t_chan_info;

    localparam logic [7:0] CFG_EVENT_THR  = 8'd0;
    localparam logic [7:0] CFG_REARM_THR  = 8'd1;
    localparam logic [7:0] CFG_DOWNSAMPLE = 8'd2;
    localparam logic [7:0] CFG_RAPID_DUR  = 8'd3;

    localparam logic [14:0] RST_EVENT_THR  = 15'd200;
    localparam logic [14:0] RST_REARM_THR  = 15'd50;
    localparam logic [7:0]  RST_DOWNSAMPLE = 8'd8;
    localparam logic [7:0]  RST_RAPID_DUR  = 8'd200;

endpackage

@@ rtl/dual_cap_touch_event_detector_unit.sv @@
// An accepted beat's result is registered in r_out, or in r_skid if r_out waits.
// One beat per cycle while o_stall is low. Both buttons share the tick, A resolved
// before B. A two-entry output buffer lets a new beat in while one result waits.
// Reset (synchronous, active low): clears history, running sums, counters and
// locks, and loads register defaults.
module dual_cap_touch_event_detector_unit #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dctd_pkg::t_in_beat  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output dctd_pkg::t_out_beat o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    logic [14:0]         r_event_thr;
    logic [14:0]         r_rearm_thr;
    logic [7:0]          r_downsample;
    logic [7:0]          r_rapid_dur;
    logic [7:0]          r_rapid_a;
    logic [7:0]          r_rapid_b;
    logic [1:0]          r_press_lock;
    logic [1:0]          r_release_lock;
    logic                r_out_valid;
    logic                r_skid_valid;
    dctd_pkg::t_out_beat r_out;
    dctd_pkg::t_out_beat r_skid;

    logic                 w_accept;
    logic                 w_out_fire;
    logic                 w_take_a;
    logic                 w_take_b;
    logic                 w_ev_a;
    logic                 w_ev_b;
    logic [7:0]           w_rapid_a_dec;
    logic [7:0]           w_rapid_b_mid;
    logic [7:0]           w_rapid_b_dec;
    dctd_pkg::t_chan_info w_info_a;
    dctd_pkg::t_chan_info w_info_b;
    dctd_pkg::t_hp_flags  w_fa;
    dctd_pkg::t_hp_flags  w_fb;
    dctd_pkg::t_status    w_st_a;
    dctd_pkg::t_status    w_st_b;
    logic [1:0]           n_press_lock;
    logic [1:0]           n_release_lock;
    dctd_pkg::t_out_beat  w_res;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    assign w_accept    = i_valid && !r_skid_valid;
    assign w_out_fire  = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_event_thr  <= dctd_pkg::RST_EVENT_THR;
            r_rearm_thr  <= dctd_pkg::RST_REARM_THR;
            r_downsample <= dctd_pkg::RST_DOWNSAMPLE;
            r_rapid_dur  <= dctd_pkg::RST_RAPID_DUR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dctd_pkg::CFG_EVENT_THR:  r_event_thr  <= i_cfg_data[14:0];
                dctd_pkg::CFG_REARM_THR:  r_rearm_thr  <= i_cfg_data[14:0];
                dctd_pkg::CFG_DOWNSAMPLE: r_downsample <= i_cfg_data[7:0];
                dctd_pkg::CFG_RAPID_DUR:  r_rapid_dur  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    dctd_chan #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_chan_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_take       (w_take_a),
        .i_count      (i_in.count_a),
        .i_event_thr  (r_event_thr),
        .i_rearm_thr  (r_rearm_thr),
        .i_downsample (r_downsample),
        .o_info       (w_info_a)
    );

    dctd_chan #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_chan_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_take       (w_take_b),
        .i_count      (i_in.count_b),
        .i_event_thr  (r_event_thr),
        .i_rearm_thr  (r_rearm_thr),
        .i_downsample (r_downsample),
        .o_info       (w_info_b)
    );

    // A event reloads B's window before B is sensed this tick
    assign w_rapid_a_dec = (r_rapid_a != 8'd0) ? r_rapid_a - 8'd1 : 8'd0;
    assign w_take_a      = w_info_a.skip_match || (w_rapid_a_dec != 8'd0);
    assign w_fa          = w_take_a ? w_info_a.take : w_info_a.hold;
    assign w_ev_a        = w_fa.press_hit || w_fa.rel_hit;
    assign w_rapid_b_mid = w_ev_a ? r_rapid_dur : r_rapid_b;
    assign w_rapid_b_dec = (w_rapid_b_mid != 8'd0) ? w_rapid_b_mid - 8'd1 : 8'd0;
    assign w_take_b      = w_info_b.skip_match || (w_rapid_b_dec != 8'd0);
    assign w_fb          = w_take_b ? w_info_b.take : w_info_b.hold;
    assign w_ev_b        = w_fb.press_hit || w_fb.rel_hit;

    always_comb begin
        n_press_lock   = r_press_lock;
        n_release_lock = r_release_lock;
        w_st_a         = dctd_pkg::ST_NONE;
        w_st_b         = dctd_pkg::ST_NONE;

        if (w_fa.press_hit) begin
            if (!r_press_lock[0]) begin
                w_st_a          = dctd_pkg::ST_PRESS;
                n_press_lock[0] = 1'b1;
            end
        end else if (w_fa.press_clear) begin
            n_press_lock[0] = 1'b0;
        end
        if (w_fa.rel_hit) begin
            if (!r_release_lock[0]) begin
                w_st_a            = dctd_pkg::ST_RELEASE;
                n_release_lock[0] = 1'b1;
            end
        end else if (w_fa.rel_clear) begin
            n_release_lock[0] = 1'b0;
        end

        if (w_fb.press_hit) begin
            if (!r_press_lock[1]) begin
                w_st_b          = dctd_pkg::ST_PRESS;
                n_press_lock[1] = 1'b1;
            end
        end else if (w_fb.press_clear) begin
            n_press_lock[1] = 1'b0;
        end
        if (w_fb.rel_hit) begin
            if (!r_release_lock[1]) begin
                w_st_b            = dctd_pkg::ST_RELEASE;
                n_release_lock[1] = 1'b1;
            end
        end else if (w_fb.rel_clear) begin
            n_release_lock[1] = 1'b0;
        end

        w_res.status_a = w_st_a;
        w_res.status_b = w_st_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rapid_a      <= '0;
            r_rapid_b      <= '0;
            r_press_lock   <= '0;
            r_release_lock <= '0;
        end else if (w_accept) begin
            r_rapid_a      <= (w_ev_a || w_ev_b) ? r_rapid_dur : w_rapid_a_dec;
            r_rapid_b      <= w_ev_b ? r_rapid_dur : w_rapid_b_dec;
            r_press_lock   <= n_press_lock;
            r_release_lock <= n_release_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

@@ rtl/dctd_hp.sv @@
module dctd_hp #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic [15:0]         i_sample,
    input  logic [15:0]         i_sum,
    input  logic [15:0]         i_oldest,
    input  logic [14:0]         i_event_thr,
    input  logic [14:0]         i_rearm_thr,
    output logic [15:0]         o_sum,
    output dctd_pkg::t_hp_flags o_flags
);

    localparam logic [15:0] DEPTH_W = 16'(HISTORY_DEPTH);

    logic [15:0]        w_prod;
    logic [15:0]        w_raw;
    logic signed [16:0] w_hp;
    logic signed [16:0] w_et;
    logic signed [16:0] w_rt;

    assign o_sum  = i_sum + i_sample - i_oldest;
    assign w_prod = i_sample * DEPTH_W;
    assign w_raw  = w_prod - o_sum;
    assign w_hp   = {w_raw[15], w_raw};
    assign w_et   = {2'b00, i_event_thr};
    assign w_rt   = {2'b00, i_rearm_thr};

    assign o_flags.press_hit   = w_hp < -w_et;
    assign o_flags.press_clear = w_hp > -w_rt;
    assign o_flags.rel_hit     = w_hp > w_et;
    assign o_flags.rel_clear   = w_hp < w_rt;

endmodule

@@ rtl/dctd_chan.sv @@
module dctd_chan #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_take,
    input  logic [15:0]          i_count,
    input  logic [14:0]          i_event_thr,
    input  logic [14:0]          i_rearm_thr,
    input  logic [7:0]           i_downsample,
    output dctd_pkg::t_chan_info o_info
);

    logic [15:0] r_hist [HISTORY_DEPTH];
    logic [15:0] r_sum;
    logic [7:0]  r_skip;
    logic [7:0]  n_skip_inc;
    logic [15:0] w_sum_take;
    logic [15:0] w_sum_hold;

    assign n_skip_inc        = r_skip + 8'd1;
    assign o_info.skip_match = n_skip_inc == i_downsample;

    dctd_hp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hp_take (
        .i_sample    (i_count),
        .i_sum       (r_sum),
        .i_oldest    (r_hist[HISTORY_DEPTH-1]),
        .i_event_thr (i_event_thr),
        .i_rearm_thr (i_rearm_thr),
        .o_sum       (w_sum_take),
        .o_flags     (o_info.take)
    );

    dctd_hp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hp_hold (
        .i_sample    (r_hist[0]),
        .i_sum       (r_sum),
        .i_oldest    (r_hist[HISTORY_DEPTH-1]),
        .i_event_thr (i_event_thr),
        .i_rearm_thr (i_rearm_thr),
        .o_sum       (w_sum_hold),
        .o_flags     (o_info.hold)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_sum  <= '0;
            r_skip <= '0;
        end else if (i_accept) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= i_take ? i_count : r_hist[0];
            r_sum     <= i_take ? w_sum_take : w_sum_hold;
            r_skip    <= i_take ? 8'd0 : n_skip_inc;
        end
    end

endmodule
